@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file egcd_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define EGCD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define EGCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define EGCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/egcd_pkg.sv @@
// Shared types and constants for the extended gcd block.
// No dependencies.
package egcd_pkg;

  localparam int unsigned QDEPTH = 2;

  typedef struct packed {
    logic valid;
    logic swapped;
  } egcd_tag_t;

endpackage

@@ rtl/extended_euclid_gcd.sv @@
// Extended Euclidean gcd. Each input word (operand_a, operand_b) yields one
// output word with gcd_value and coefficients so operand_a*coef_a +
// operand_b*coef_b = gcd_value. A two-entry queue decouples input from the
// engine, which handles one word at a time; each remainder step runs a
// restoring divider that yields one quotient bit per cycle.
// Depends on egcd_pkg, egcd_front, egcd_back.
module extended_euclid_gcd #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [OPERAND_WIDTH-1:0]      operand_a_i,
  input  logic [OPERAND_WIDTH-1:0]      operand_b_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [OPERAND_WIDTH-1:0]      gcd_value_o,
  output logic signed [OPERAND_WIDTH:0] coef_a_o,
  output logic signed [OPERAND_WIDTH:0] coef_b_o
);
  import egcd_pkg::*;

  egcd_tag_t                head_tag;
  logic [OPERAND_WIDTH-1:0] head_big, head_small;
  logic                     pop;

  egcd_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operand_a_i  (operand_a_i),
    .operand_b_i  (operand_b_i),
    .head_tag_o   (head_tag),
    .head_big_o   (head_big),
    .head_small_o (head_small),
    .pop_i        (pop)
  );

  egcd_back #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_tag_i   (head_tag),
    .head_big_i   (head_big),
    .head_small_i (head_small),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .gcd_value_o  (gcd_value_o),
    .coef_a_o     (coef_a_o),
    .coef_b_o     (coef_b_o)
  );

endmodule

@@ rtl/egcd_front.sv @@
// Front end: orders the operands (larger first) and queues words for the engine.
// Depends on egcd_pkg.
module egcd_front #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [OPERAND_WIDTH-1:0]  operand_a_i,
  input  logic [OPERAND_WIDTH-1:0]  operand_b_i,
  output egcd_pkg::egcd_tag_t       head_tag_o,
  output logic [OPERAND_WIDTH-1:0]  head_big_o,
  output logic [OPERAND_WIDTH-1:0]  head_small_o,
  input  logic                      pop_i
);
  import egcd_pkg::*;

  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CntW = $clog2(QDEPTH + 1);

  logic [OPERAND_WIDTH-1:0] big_mem [QDEPTH];
  logic [OPERAND_WIDTH-1:0] small_mem [QDEPTH];
  logic                     swap_mem [QDEPTH];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop, swap;

  assign swap       = operand_b_i > operand_a_i;
  assign in_ready_o = count_q != CntW'(QDEPTH);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != '0);

  assign head_tag_o.valid   = count_q != '0;
  assign head_tag_o.swapped = swap_mem[rd_ptr_q];
  assign head_big_o         = big_mem[rd_ptr_q];
  assign head_small_o       = small_mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    count_d = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      big_mem[wr_ptr_q]   <= swap ? operand_b_i : operand_a_i;
      small_mem[wr_ptr_q] <= swap ? operand_a_i : operand_b_i;
      swap_mem[wr_ptr_q]  <= swap;
    end
  end

endmodule

@@ rtl/egcd_back.sv @@
// Back end: Euclid loop with a bit-serial restoring divider; the quotient times
// the coefficients is accumulated by shift-add. Holds the output register.
// Depends on egcd_pkg.
module egcd_back #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  egcd_pkg::egcd_tag_t       head_tag_i,
  input  logic [OPERAND_WIDTH-1:0]  head_big_i,
  input  logic [OPERAND_WIDTH-1:0]  head_small_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [OPERAND_WIDTH-1:0]  gcd_value_o,
  output logic signed [OPERAND_WIDTH:0] coef_a_o,
  output logic signed [OPERAND_WIDTH:0] coef_b_o
);
  import egcd_pkg::*;

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CW   = OPERAND_WIDTH + 1;
  localparam int unsigned CntW = $clog2(OPERAND_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_UPD,
    S_DONE
  } state_e;

  state_e          state_q;
  logic [W-1:0]    r0_q, r1_q, rem_q, dvd_q;
  logic [CW-1:0]   s0_q, s1_q, t0_q, t1_q, acc_s_q, acc_t_q;
  logic [CntW-1:0] cnt_q;
  logic            swap_q;

  logic [W:0]      rem_sh, rem_sub;
  logic            ge;
  logic [CW-1:0]   acc_s_d, acc_t_d;

  assign pop_o   = (state_q == S_IDLE) && head_tag_i.valid;
  assign rem_sh  = {rem_q, dvd_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, r1_q};
  assign ge      = rem_sh >= {1'b0, r1_q};
  assign acc_s_d = {acc_s_q[CW-2:0], 1'b0} + (ge ? s1_q : '0);
  assign acc_t_d = {acc_t_q[CW-2:0], 1'b0} + (ge ? t1_q : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != S_DONE)) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (head_tag_i.valid) begin
            state_q <= S_TEST;
          end
        end
        S_TEST: begin
          state_q <= (r1_q == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (cnt_q == '0) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          state_q <= S_TEST;
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        r0_q   <= head_big_i;
        r1_q   <= head_small_i;
        swap_q <= head_tag_i.swapped;
        s0_q   <= CW'(1);
        t0_q   <= '0;
        s1_q   <= '0;
        t1_q   <= CW'(1);
      end
      S_TEST: begin
        rem_q   <= '0;
        dvd_q   <= r0_q;
        cnt_q   <= CntW'(W - 1);
        acc_s_q <= '0;
        acc_t_q <= '0;
      end
      S_DIV: begin
        rem_q   <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        dvd_q   <= {dvd_q[W-2:0], 1'b0};
        acc_s_q <= acc_s_d;
        acc_t_q <= acc_t_d;
        cnt_q   <= cnt_q - CntW'(1);
      end
      S_UPD: begin
        r0_q <= r1_q;
        r1_q <= rem_q;
        s0_q <= s1_q;
        t0_q <= t1_q;
        s1_q <= s0_q - acc_s_q;
        t1_q <= t0_q - acc_t_q;
      end
      S_DONE: begin
        if (!out_valid_o || out_ready_i) begin
          gcd_value_o <= r0_q;
          coef_a_o    <= swap_q ? t0_q : s0_q;
          coef_b_o    <= swap_q ? s0_q : t0_q;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/egcd_checker.sv @@
// Port-level checker for extended_euclid_gcd, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module egcd_checker #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [OPERAND_WIDTH-1:0]      gcd_value_o,
  input logic signed [OPERAND_WIDTH:0] coef_a_o,
  input logic signed [OPERAND_WIDTH:0] coef_b_o
);

  logic [3:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  `EGCD_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "out word dropped while stalled")
  `EGCD_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(gcd_value_o) && $stable(coef_a_o) && $stable(coef_b_o), "out word changed while stalled")
  `EGCD_ASSERT_IMP(a_no_orphan, clk_i, rst_ni, out_valid_o, pend_q != 4'd0, "out word without matching input")
  `EGCD_ASSERT_IMP(a_zero_gcd, clk_i, rst_ni, out_valid_o && (gcd_value_o == '0), (coef_a_o == (OPERAND_WIDTH+1)'(1)) && (coef_b_o == '0), "bad coefficients for zero gcd")

endmodule

bind extended_euclid_gcd egcd_checker #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_egcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .gcd_value_o (gcd_value_o),
  .coef_a_o    (coef_a_o),
  .coef_b_o    (coef_b_o)
);
